// ===== rtl/ppzb_pkg.sv =====
// shared types, constants and register codes for the perspective point plotter
package ppzb_pkg;

   localparam int MAX_PIXELS_DEFAULT = 8192;

   localparam int IDX_W   = 13;
   localparam int DEPTH_W = 24;
   localparam int SYM_W   = 8;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes, taken from paddr[4:2]
   localparam logic [2:0] REG_CAM_DISTANCE = 3'd0;
   localparam logic [2:0] REG_FOCAL_SCALE  = 3'd1;
   localparam logic [2:0] REG_SCREEN_WIDTH = 3'd2;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
   localparam logic [2:0] REG_BACKGROUND   = 3'd4;

   localparam logic [7:0] CAM_DISTANCE_RESET = 8'd40;
   localparam logic [9:0] FOCAL_SCALE_RESET  = 10'd60;
   localparam logic [8:0] SCREEN_WIDTH_RESET = 9'd160;
   localparam logic [7:0] SCREEN_HEIGHT_RESET = 8'd50;
   localparam logic [SYM_W-1:0] SYM_RESET    = 8'd32;

   localparam logic [1:0] STATUS_DRAWN  = 2'd0;
   localparam logic [1:0] STATUS_HIDDEN = 2'd1;
   localparam logic [1:0] STATUS_OFF    = 2'd2;
   localparam logic [1:0] STATUS_READ   = 2'd3;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic [SYM_W-1:0]   plot_symbol;
      logic [IDX_W-1:0]   read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] pixel_index;
      logic [SYM_W-1:0] pixel_symbol;
   } rsp_type;

endpackage

// ===== rtl/perspective_point_zbuffer_plot_core.sv =====
// top level of the perspective point plotter with depth buffer and read-and-clear
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_stall     req_data  (ppzb_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_stall     rsp_data  (ppzb_pkg::rsp_type)
//   config    in/out     psel penable pwrite pready paddr pwdata prdata
//
// one item in flight at a time; a plot item runs through the 25 step bit-serial
// reciprocal, eight arithmetic and store steps and the idle state that takes the next item
// a point at or behind the camera goes from idle straight to the finish step, a
// read-and-clear goes through the check and finish steps
// after reset a clearing pass writes every address of both stores; req_stall is
// high during it, configuration writes are taken as ever
// the result sits in an output register, so a stalled rsp side only holds the block
// once the next item is ready to deliver its result
module perspective_point_zbuffer_plot_core #(
   parameter int MAX_PIXELS = ppzb_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppzb_pkg::req_type                   req_data,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ppzb_pkg::rsp_type                   rsp_data,
   // configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ppzb_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ppzb_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ppzb_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import ppzb_pkg::*;

   localparam int ADDR_W = $clog2(MAX_PIXELS);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_MUL1,
      S_MUL2,
      S_SUM,
      S_TRUNC,
      S_INDEX,
      S_OFFSET,
      S_CHECK,
      S_FINISH
   } state_type;

   // configuration registers
   logic [7:0]       cam_ff;
   logic [9:0]       focal_ff;
   logic [8:0]       width_ff;
   logic [7:0]       height_ff;
   logic [SYM_W-1:0] bg_ff;
   logic             csr_wr;

   // control
   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             off_ff, off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // item payload
   logic             mode_ff, mode_in;
   logic signed [15:0] py_ff, py_in;
   logic signed [15:0] pz_ff, pz_in;
   logic [SYM_W-1:0] sym_ff, sym_in;

   // datapath
   logic [16:0]      dv_ff, dv_in;
   logic [16:0]      rem_ff, rem_in;
   logic [24:0]      quo_ff, quo_in;
   logic [DEPTH_W-1:0] inv_ff, inv_in;
   logic [33:0]      fi_ff, fi_in;
   logic signed [50:0] ty_ff, ty_in;
   logic signed [50:0] tz_ff, tz_in;
   logic signed [51:0] vy_ff, vy_in;
   logic signed [51:0] vz_ff, vz_in;
   logic signed [27:0] col_ff, col_in;
   logic signed [27:0] row_ff, row_in;
   logic [39:0]      idx_ff, idx_in;

   // combinational helpers
   logic signed [17:0] cam_gap;
   logic [17:0]      trial;
   logic             trial_ge;
   logic signed [51:0] vy_bias, vz_bias;
   logic signed [28:0] h_minus_row;
   logic signed [38:0] row_offset;
   logic [16:0]      frame_size;
   logic             out_of_range;
   logic             out_free;
   logic             win;

   // memory port
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [DEPTH_W-1:0] depth_wr, depth_rd;
   logic [SYM_W-1:0]   symbol_wr, symbol_rd;

   // ---------------------------------------------------------------- configuration
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff    <= CAM_DISTANCE_RESET;
         focal_ff  <= FOCAL_SCALE_RESET;
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
         bg_ff     <= SYM_RESET;
      end else if (csr_wr) begin
         case (paddr[4:2])
            REG_CAM_DISTANCE:  cam_ff    <= pwdata[7:0];
            REG_FOCAL_SCALE:   focal_ff  <= pwdata[9:0];
            REG_SCREEN_WIDTH:  width_ff  <= pwdata[8:0];
            REG_SCREEN_HEIGHT: height_ff <= pwdata[7:0];
            REG_BACKGROUND:    bg_ff     <= pwdata[SYM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_CAM_DISTANCE:  prdata = CSR_DATA_W'(cam_ff);
         REG_FOCAL_SCALE:   prdata = CSR_DATA_W'(focal_ff);
         REG_SCREEN_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_SCREEN_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_BACKGROUND:    prdata = CSR_DATA_W'(bg_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- arithmetic
   // distance from camera in q8.8, positive means in front
   assign cam_gap = $signed({2'b00, cam_ff, 8'h00}) - $signed({{2{req_data.point_x[15]}},
                                                              req_data.point_x});

   // restoring division step for 2^24 / d, one quotient bit a cycle
   assign trial    = {rem_ff, (cnt_ff == 5'd24)};
   assign trial_ge = (trial >= {1'b0, dv_ff});

   // truncation toward zero: add 2^24-1 to negative values before the shift
   assign vy_bias = vy_ff + $signed({28'd0, {24{vy_ff[51]}}});
   assign vz_bias = vz_ff + $signed({28'd0, {24{vz_ff[51]}}});

   // (h - row) * w from the registered row
   assign h_minus_row = $signed({21'd0, height_ff}) - 29'(row_ff);
   assign row_offset  = h_minus_row * $signed({1'b0, width_ff});

   assign frame_size  = 17'(width_ff) * 17'(height_ff);

   // only the linear index is checked; frame size does not apply to reads
   assign out_of_range = idx_ff[39]
                      || (!mode_ff && (idx_ff >= 40'(frame_size)))
                      || (idx_ff >= 40'(MAX_PIXELS));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign win      = (inv_ff > depth_rd);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mode_in      = mode_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      sym_in       = sym_ff;
      dv_in        = dv_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      inv_in       = inv_ff;
      fi_in        = fi_ff;
      ty_in        = ty_ff;
      tz_in        = tz_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      depth_wr     = '0;
      symbol_wr    = SYM_RESET;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MAX_PIXELS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_data.mode;
               py_in   = req_data.point_y;
               pz_in   = req_data.point_z;
               sym_in  = req_data.plot_symbol;
               off_in  = 1'b0;
               idx_in  = 40'(req_data.read_index);
               dv_in   = cam_gap[16:0];
               rem_in  = '0;
               quo_in  = '0;
               cnt_in  = 5'd24;
               if (req_data.mode) begin
                  state_in = S_CHECK;
               end else if (cam_gap[17] || (cam_gap == '0)) begin
                  // at or behind the camera
                  off_in   = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_DIV;
               end
            end
         end

         S_DIV: begin
            rem_in = trial_ge ? 17'(trial - {1'b0, dv_ff}) : trial[16:0];
            quo_in = {quo_ff[23:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 5'd0) begin
               state_in = S_MUL1;
            end
         end

         S_MUL1: begin
            // saturate the one case d = 1
            inv_in   = quo_ff[24] ? '1 : quo_ff[DEPTH_W-1:0];
            state_in = S_MUL2;
         end

         S_MUL2: begin
            fi_in    = 34'(focal_ff) * 34'(inv_ff);
            state_in = S_SUM;
         end

         S_SUM: begin
            ty_in    = $signed({1'b0, fi_ff}) * py_ff;
            tz_in    = $signed({1'b0, fi_ff}) * pz_ff;
            state_in = S_TRUNC;
         end

         S_TRUNC: begin
            vy_in    = $signed({20'd0, width_ff[8:1], 24'd0}) + $signed({ty_ff, 1'b0});
            vz_in    = $signed({21'd0, height_ff[7:1], 24'd0}) + 52'(tz_ff);
            state_in = S_INDEX;
         end

         S_INDEX: begin
            col_in   = vy_bias[51:24];
            row_in   = vz_bias[51:24];
            state_in = S_OFFSET;
         end

         S_OFFSET: begin
            // linear index from the registered column and row
            idx_in   = 40'(col_ff) + 40'(row_offset);
            state_in = S_CHECK;
         end

         S_CHECK: begin
            state_in  = S_FINISH;
            off_in    = out_of_range;
            mem_rd_en = !out_of_range;
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (off_ff) begin
                  rsp_data_in.status       = STATUS_OFF;
                  rsp_data_in.pixel_index  = '0;
                  rsp_data_in.pixel_symbol = '0;
               end else if (mode_ff) begin
                  rsp_data_in.status       = STATUS_READ;
                  rsp_data_in.pixel_index  = idx_ff[IDX_W-1:0];
                  rsp_data_in.pixel_symbol = symbol_rd;
                  mem_wr_en = 1'b1;
                  depth_wr  = '0;
                  symbol_wr = bg_ff;
               end else if (win) begin
                  rsp_data_in.status       = STATUS_DRAWN;
                  rsp_data_in.pixel_index  = idx_ff[IDX_W-1:0];
                  rsp_data_in.pixel_symbol = sym_ff;
                  mem_wr_en = 1'b1;
                  depth_wr  = inv_ff;
                  symbol_wr = sym_ff;
               end else begin
                  rsp_data_in.status       = STATUS_HIDDEN;
                  rsp_data_in.pixel_index  = idx_ff[IDX_W-1:0];
                  rsp_data_in.pixel_symbol = symbol_rd;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
      mode_ff     <= mode_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      sym_ff      <= sym_in;
      dv_ff       <= dv_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      inv_ff      <= inv_in;
      fi_ff       <= fi_in;
      ty_ff       <= ty_in;
      tz_ff       <= tz_in;
      vy_ff       <= vy_in;
      vz_ff       <= vz_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      idx_ff      <= idx_in;
   end

   // ---------------------------------------------------------------- stores
   assign req_stall = (state_ff != S_IDLE);
   assign mem_addr  = (state_ff == S_CLEAR) ? clr_ff : idx_ff[ADDR_W-1:0];

   ppzb_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (MAX_PIXELS)
   ) u_depth_store (
      .clock   (clock),
      .addr    (mem_addr),
      .wr_en   (mem_wr_en),
      .wr_data (depth_wr),
      .rd_en   (mem_rd_en),
      .rd_data (depth_rd)
   );

   ppzb_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_PIXELS)
   ) u_symbol_store (
      .clock   (clock),
      .addr    (mem_addr),
      .wr_en   (mem_wr_en),
      .wr_data (symbol_wr),
      .rd_en   (mem_rd_en),
      .rd_data (symbol_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/ppzb_ram.sv =====
// generic single-port synchronous ram with registered read
module ppzb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
